// File: sv/crmv_pkg.sv
// Shared types and constants for the camera ray midpoint vector unit.
// No dependencies; imported by the solver, the point pipeline and the top level.
package crmv_pkg;

    localparam int NumCfg = 7;
    localparam int AddrW  = 5;
    localparam int QEntW  = 31;

    // Register index of each configuration word
    typedef enum logic [2:0] {
        REG_QUAT_W  = 3'd0,
        REG_QUAT_X  = 3'd1,
        REG_QUAT_Y  = 3'd2,
        REG_QUAT_Z  = 3'd3,
        REG_TRANS_X = 3'd4,
        REG_TRANS_Y = 3'd5,
        REG_TRANS_Z = 3'd6,
        REG_NONE    = 3'd7
    } reg_idx_t;

    localparam logic signed [31:0] QuatOne = 32'sd1073741824;

    // Pose as held in the configuration registers
    typedef struct packed {
        logic signed [31:0] qw;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
    } pose_t;

    // Status of the solved pose
    typedef struct packed {
        logic det_zero;
        logic qsat;
    } sol_t;

    typedef logic signed [QEntW-1:0] qent_t;

endpackage

// File: sv/crmv_solve.sv
// Per-pose solver: rotation, direction normalisation, Gram system and the 3x3 matrix Q.
// Depends on crmv_pkg. Runs a step sequencer with one restoring divider.
module crmv_solve (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr,
    input  crmv_pkg::pose_t    pose,
    output logic               busy,
    output crmv_pkg::sol_t     sol,
    output crmv_pkg::qent_t    qmat [9]
);
    import crmv_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_QP, S_ROT, S_NORM, S_RV, S_GRAM, S_DET1, S_DET2,
        S_UW, S_NUM1, S_NUM2, S_DIV
    } state_t;

    state_t                state_reg;
    logic [3:0]            k_reg;
    logic [1:0]            ii_reg;
    logic [1:0]            jj_reg;
    logic [4:0]            c_reg;
    logic signed [33:0]    pq_reg [9];
    logic signed [31:0]    rot_reg [3][3];
    logic signed [15:0]    t_reg [3];
    logic signed [16:0]    r_reg [3];
    logic signed [49:0]    acc_reg;
    logic signed [33:0]    a00_reg;
    logic signed [33:0]    a01_reg;
    logic signed [33:0]    a11_reg;
    logic signed [71:0]    mp_reg;
    logic [71:0]           det_reg;
    logic signed [51:0]    u_reg [3];
    logic signed [51:0]    w_reg [3];
    logic                  neg_reg;
    logic [71:0]           rem_reg;
    logic [29:0]           quo_reg;
    qent_t                 qmat_reg [9];
    logic                  qsat_reg;
    logic                  dz_reg;

    logic signed [31:0]    qa;
    logic signed [31:0]    qb;
    logic signed [63:0]    qprod;
    logic signed [31:0]    rot_n [3][3];
    logic [31:0]           tabs [3];
    logic [31:0]           tmax;
    logic [5:0]            blen;
    logic signed [31:0]    tsh [3];
    logic signed [49:0]    rv_acc;
    logic signed [19:0]    rv_sh;
    logic signed [16:0]    rv_clamp;
    logic signed [33:0]    gram;
    logic [1:0]            uj;
    logic signed [51:0]    uw_val;
    logic signed [71:0]    numv;
    logic [71:0]           mag;
    logic [71:0]           dcmp;
    logic [71:0]           rsh;
    logic                  ge;
    logic [29:0]           qnew;
    logic [3:0]            qidx;

    // Clamp a rotation entry to [-1.0, +1.0]
    function automatic logic signed [31:0] rclamp(input logic signed [39:0] v);
        logic signed [31:0] res;
        if (v > 40'sd1073741824)
            res = QuatOne;
        else if (v < -40'sd1073741824)
            res = -QuatOne;
        else
            res = v[31:0];
        return res;
    endfunction

    // Pick the quaternion product operands for step k
    always_comb
    begin
        unique case (k_reg)
            4'd0:    begin qa = pose.qx; qb = pose.qx; end
            4'd1:    begin qa = pose.qy; qb = pose.qy; end
            4'd2:    begin qa = pose.qz; qb = pose.qz; end
            4'd3:    begin qa = pose.qx; qb = pose.qy; end
            4'd4:    begin qa = pose.qx; qb = pose.qz; end
            4'd5:    begin qa = pose.qy; qb = pose.qz; end
            4'd6:    begin qa = pose.qw; qb = pose.qx; end
            4'd7:    begin qa = pose.qw; qb = pose.qy; end
            default: begin qa = pose.qw; qb = pose.qz; end
        endcase
        qprod = qa * qb;
    end

    // Rotation matrix from the stored products (xx yy zz xy xz yz wx wy wz)
    always_comb
    begin
        rot_n[0][0] = rclamp(40'(QuatOne) - 40'sd2 * (40'(pq_reg[1]) + 40'(pq_reg[2])));
        rot_n[0][1] = rclamp(40'sd2 * (40'(pq_reg[3]) - 40'(pq_reg[8])));
        rot_n[0][2] = rclamp(40'sd2 * (40'(pq_reg[4]) + 40'(pq_reg[7])));
        rot_n[1][0] = rclamp(40'sd2 * (40'(pq_reg[3]) + 40'(pq_reg[8])));
        rot_n[1][1] = rclamp(40'(QuatOne) - 40'sd2 * (40'(pq_reg[0]) + 40'(pq_reg[2])));
        rot_n[1][2] = rclamp(40'sd2 * (40'(pq_reg[5]) - 40'(pq_reg[6])));
        rot_n[2][0] = rclamp(40'sd2 * (40'(pq_reg[4]) - 40'(pq_reg[7])));
        rot_n[2][1] = rclamp(40'sd2 * (40'(pq_reg[5]) + 40'(pq_reg[6])));
        rot_n[2][2] = rclamp(40'(QuatOne) - 40'sd2 * (40'(pq_reg[0]) + 40'(pq_reg[1])));
    end

    // Normalise T to a 14-bit direction
    always_comb
    begin
        tabs[0] = pose.tx[31] ? 32'(-pose.tx) : 32'(pose.tx);
        tabs[1] = pose.ty[31] ? 32'(-pose.ty) : 32'(pose.ty);
        tabs[2] = pose.tz[31] ? 32'(-pose.tz) : 32'(pose.tz);
        tmax = tabs[0];
        if (tabs[1] > tmax)
            tmax = tabs[1];
        if (tabs[2] > tmax)
            tmax = tabs[2];
        blen = 6'd0;
        for (int n = 0; n < 32; n++)
        begin
            if (tmax[n])
                blen = 6'(n + 1);
        end
        if (blen > 6'd14)
        begin
            tsh[0] = pose.tx >>> (blen - 6'd14);
            tsh[1] = pose.ty >>> (blen - 6'd14);
            tsh[2] = pose.tz >>> (blen - 6'd14);
        end
        else
        begin
            tsh[0] = pose.tx <<< (6'd14 - blen);
            tsh[1] = pose.ty <<< (6'd14 - blen);
            tsh[2] = pose.tz <<< (6'd14 - blen);
        end
    end

    // One term of r = R^T t per cycle
    always_comb
    begin
        rv_acc = ((jj_reg == 2'd0) ? 50'sd0 : acc_reg)
                 + 50'(rot_reg[jj_reg][ii_reg]) * 50'(t_reg[jj_reg]);
        rv_sh  = rv_acc[49:30];
        if (rv_sh > 20'sd32768)
            rv_clamp = 17'sd32768;
        else if (rv_sh < -20'sd32768)
            rv_clamp = -17'sd32768;
        else
            rv_clamp = rv_sh[16:0];
    end

    // Gram entries, u and w
    always_comb
    begin
        unique case (k_reg[1:0])
            2'd0:    gram = 34'(t_reg[0]) * 34'(t_reg[0]) + 34'(t_reg[1]) * 34'(t_reg[1])
                          + 34'(t_reg[2]) * 34'(t_reg[2]);
            2'd1:    gram = 34'(t_reg[0]) * 34'(r_reg[0]) + 34'(t_reg[1]) * 34'(r_reg[1])
                          + 34'(t_reg[2]) * 34'(r_reg[2]);
            default: gram = 34'(r_reg[0]) * 34'(r_reg[0]) + 34'(r_reg[1]) * 34'(r_reg[1])
                          + 34'(r_reg[2]) * 34'(r_reg[2]);
        endcase
        uj = k_reg[2:1];
        if (!k_reg[0])
            uw_val = 52'(a11_reg) * 52'(t_reg[uj]) - 52'(a01_reg) * 52'(r_reg[uj]);
        else
            uw_val = 52'(a00_reg) * 52'(r_reg[uj]) - 52'(a01_reg) * 52'(t_reg[uj]);
    end

    // Numerator, magnitude and one restoring divide step
    always_comb
    begin
        numv = mp_reg - 72'(r_reg[ii_reg]) * 72'(w_reg[jj_reg]);
        mag  = numv[71] ? 72'(-numv) : 72'(numv);
        dcmp = (c_reg == 5'd0) ? (det_reg << 1) : det_reg;
        rsh  = (c_reg >= 5'd2) ? (rem_reg << 1) : rem_reg;
        ge   = (rsh >= dcmp);
        qnew = {quo_reg[28:0], ge};
        qidx = 4'({2'b00, ii_reg} * 4'd3) + {2'b00, jj_reg};
    end

    // Sequence the pose solution
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_QP;
            k_reg     <= '0;
            ii_reg    <= '0;
            jj_reg    <= '0;
            c_reg     <= '0;
            qsat_reg  <= 1'b0;
            dz_reg    <= 1'b0;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            a00_reg   <= '0;
            a01_reg   <= '0;
            a11_reg   <= '0;
            mp_reg    <= '0;
            det_reg   <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            for (int n = 0; n < 9; n++)
            begin
                pq_reg[n]   <= '0;
                qmat_reg[n] <= '0;
            end
            for (int n = 0; n < 3; n++)
            begin
                t_reg[n] <= '0;
                r_reg[n] <= '0;
                u_reg[n] <= '0;
                w_reg[n] <= '0;
                for (int m = 0; m < 3; m++)
                    rot_reg[n][m] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            // A new pose restarts the solution from the top
            state_reg <= S_QP;
            k_reg     <= '0;
            qsat_reg  <= 1'b0;
            dz_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                end
                S_QP:
                begin
                    pq_reg[k_reg] <= qprod[63:30];
                    if (k_reg == 4'd8)
                        state_reg <= S_ROT;
                    else
                        k_reg <= k_reg + 4'd1;
                end
                S_ROT:
                begin
                    rot_reg   <= rot_n;
                    state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    for (int n = 0; n < 3; n++)
                        t_reg[n] <= tsh[n][15:0];
                    ii_reg    <= '0;
                    jj_reg    <= '0;
                    state_reg <= S_RV;
                end
                S_RV:
                begin
                    acc_reg <= rv_acc;
                    if (jj_reg == 2'd2)
                    begin
                        r_reg[ii_reg] <= rv_clamp;
                        jj_reg        <= '0;
                        if (ii_reg == 2'd2)
                        begin
                            k_reg     <= '0;
                            state_reg <= S_GRAM;
                        end
                        else
                            ii_reg <= ii_reg + 2'd1;
                    end
                    else
                        jj_reg <= jj_reg + 2'd1;
                end
                S_GRAM:
                begin
                    unique case (k_reg[1:0])
                        2'd0:    a00_reg <= gram;
                        2'd1:    a01_reg <= gram;
                        default: a11_reg <= gram;
                    endcase
                    if (k_reg == 4'd2)
                        state_reg <= S_DET1;
                    else
                        k_reg <= k_reg + 4'd1;
                end
                S_DET1:
                begin
                    mp_reg    <= 72'(a00_reg) * 72'(a11_reg);
                    state_reg <= S_DET2;
                end
                S_DET2:
                begin
                    if ((mp_reg - 72'(a01_reg) * 72'(a01_reg)) <= 72'sd0)
                    begin
                        dz_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        det_reg   <= 72'(mp_reg - 72'(a01_reg) * 72'(a01_reg));
                        k_reg     <= '0;
                        state_reg <= S_UW;
                    end
                end
                S_UW:
                begin
                    if (!k_reg[0])
                        u_reg[uj] <= uw_val;
                    else
                        w_reg[uj] <= uw_val;
                    if (k_reg == 4'd5)
                    begin
                        ii_reg    <= '0;
                        jj_reg    <= '0;
                        state_reg <= S_NUM1;
                    end
                    else
                        k_reg <= k_reg + 4'd1;
                end
                S_NUM1:
                begin
                    mp_reg    <= 72'(t_reg[ii_reg]) * 72'(u_reg[jj_reg]);
                    state_reg <= S_NUM2;
                end
                S_NUM2:
                begin
                    neg_reg <= numv[71];
                    if (mag >= (det_reg << 2))
                    begin
                        // Integer part of four or more: saturate the entry
                        qmat_reg[qidx] <= numv[71] ? -qent_t'(31'sd1073741824)
                                                   : qent_t'(31'sd1073741823);
                        qsat_reg <= 1'b1;
                        if (jj_reg == 2'd2)
                        begin
                            jj_reg <= '0;
                            if (ii_reg == 2'd2)
                                state_reg <= S_IDLE;
                            else
                            begin
                                ii_reg    <= ii_reg + 2'd1;
                                state_reg <= S_NUM1;
                            end
                        end
                        else
                        begin
                            jj_reg    <= jj_reg + 2'd1;
                            state_reg <= S_NUM1;
                        end
                    end
                    else
                    begin
                        rem_reg   <= mag;
                        quo_reg   <= '0;
                        c_reg     <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= ge ? (rsh - dcmp) : rsh;
                    quo_reg <= qnew;
                    if (c_reg == 5'd29)
                    begin
                        qmat_reg[qidx] <= neg_reg ? -qent_t'({1'b0, qnew})
                                                  : qent_t'({1'b0, qnew});
                        if (jj_reg == 2'd2)
                        begin
                            jj_reg <= '0;
                            if (ii_reg == 2'd2)
                                state_reg <= S_IDLE;
                            else
                            begin
                                ii_reg    <= ii_reg + 2'd1;
                                state_reg <= S_NUM1;
                            end
                        end
                        else
                        begin
                            jj_reg    <= jj_reg + 2'd1;
                            state_reg <= S_NUM1;
                        end
                    end
                    else
                        c_reg <= c_reg + 5'd1;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign sol.det_zero = dz_reg;
    assign sol.qsat     = qsat_reg;
    assign qmat         = qmat_reg;

    a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n) cfg_wr |=> busy)
        else $error("solver not busy after a pose write");
    a_qsat_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(qsat_reg) |-> $past(state_reg == S_NUM2))
        else $error("Q saturation flag set outside the numerator step");
    a_dz_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dz_reg) |-> $past(state_reg == S_DET2))
        else $error("zero determinant flag set outside the determinant step");

endmodule

// File: sv/crmv_pipe.sv
// Per-point pipeline: v = (p*2^28 + 2^28 + Q p) >> 29, saturated to 32 bits.
// Depends on crmv_pkg. Three register stages, one point per cycle.
module crmv_pipe (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [31:0]  px,
    input  logic signed [31:0]  py,
    input  logic signed [31:0]  pz,
    input  crmv_pkg::qent_t     qmat [9],
    input  crmv_pkg::sol_t      sol,
    output logic                out_valid,
    output logic signed [31:0]  vx,
    output logic signed [31:0]  vy,
    output logic signed [31:0]  vz,
    output logic                bad
);
    import crmv_pkg::*;

    logic                v1_reg;
    logic                v2_reg;
    logic                v3_reg;
    logic signed [31:0]  p1_reg [3];
    logic signed [62:0]  prod_reg [9];
    sol_t                sol1_reg;
    sol_t                sol2_reg;
    logic signed [65:0]  acc_reg [3];
    logic signed [31:0]  v_reg [3];
    logic                bad_reg;

    logic signed [31:0]  pin [3];
    logic signed [65:0]  acc_next [3];
    logic signed [36:0]  sh [3];
    logic signed [31:0]  v_next [3];
    logic                sat_any;

    assign pin[0] = px;
    assign pin[1] = py;
    assign pin[2] = pz;

    // Sum each row, then round and clamp
    always_comb
    begin
        sat_any = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            acc_next[i] = (66'(p1_reg[i]) <<< 28) + (66'sd1 <<< 28)
                          + 66'(prod_reg[i*3]) + 66'(prod_reg[i*3+1])
                          + 66'(prod_reg[i*3+2]);
            sh[i] = acc_reg[i][65:29];
            if (sh[i] > 37'sd2147483647)
            begin
                v_next[i] = 32'sh7FFFFFFF;
                sat_any   = 1'b1;
            end
            else if (sh[i] < -37'sd2147483648)
            begin
                v_next[i] = 32'sh80000000;
                sat_any   = 1'b1;
            end
            else
                v_next[i] = sh[i][31:0];
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage data: products, row sums, clamped result
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            p1_reg[i] <= pin[i];
            for (int j = 0; j < 3; j++)
                prod_reg[i*3+j] <= qmat[i*3+j] * pin[j];
        end
        sol1_reg <= sol;
        acc_reg  <= acc_next;
        sol2_reg <= sol1_reg;
        if (sol2_reg.det_zero)
        begin
            v_reg[0] <= '0;
            v_reg[1] <= '0;
            v_reg[2] <= '0;
            bad_reg  <= 1'b1;
        end
        else
        begin
            v_reg   <= v_next;
            bad_reg <= sol2_reg.qsat | sat_any;
        end
    end

    assign out_valid = v3_reg;
    assign vx        = v_reg[0];
    assign vy        = v_reg[1];
    assign vz        = v_reg[2];
    assign bad       = bad_reg;

endmodule

// File: sv/camera_ray_midpoint_vector_unit.sv
// Camera ray midpoint vector unit: one point per cycle while busy is low, result pipelined to done.
// done is high for one cycle per point; the receiver cannot stall the pipeline.
// After reset and after every pose write the solver holds busy high while it forms Q
// (one divider, 30 steps per unsaturated Q entry); points are taken whenever busy is low.
// Reset (rst_n, asynchronous, active low) loads the identity rotation and zero translation.
module camera_ray_midpoint_vector_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [31:0]              point_x,
    input  logic signed [31:0]              point_y,
    input  logic signed [31:0]              point_z,
    output logic                            done,
    output logic signed [31:0]              vec_x,
    output logic signed [31:0]              vec_y,
    output logic signed [31:0]              vec_z,
    output logic                            bad_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [crmv_pkg::AddrW-1:0]      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import crmv_pkg::*;

    pose_t     pose_reg;
    logic      cfg_wr;
    reg_idx_t  ridx;
    logic      accept;
    sol_t      sol;
    qent_t     qmat [9];

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign ridx   = reg_idx_t'(paddr[4:2]);
    assign accept = start & ~busy;

    // Hold the pose registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pose_reg <= '{qw: QuatOne, default: '0};
        else if (cfg_wr)
        begin
            unique case (ridx)
                REG_QUAT_W:  pose_reg.qw <= pwdata;
                REG_QUAT_X:  pose_reg.qx <= pwdata;
                REG_QUAT_Y:  pose_reg.qy <= pwdata;
                REG_QUAT_Z:  pose_reg.qz <= pwdata;
                REG_TRANS_X: pose_reg.tx <= pwdata;
                REG_TRANS_Y: pose_reg.ty <= pwdata;
                REG_TRANS_Z: pose_reg.tz <= pwdata;
                default:     pose_reg    <= pose_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (ridx)
            REG_QUAT_W:  prdata = pose_reg.qw;
            REG_QUAT_X:  prdata = pose_reg.qx;
            REG_QUAT_Y:  prdata = pose_reg.qy;
            REG_QUAT_Z:  prdata = pose_reg.qz;
            REG_TRANS_X: prdata = pose_reg.tx;
            REG_TRANS_Y: prdata = pose_reg.ty;
            REG_TRANS_Z: prdata = pose_reg.tz;
            default:     prdata = '0;
        endcase
    end

    crmv_solve u_solve (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .pose   (pose_reg),
        .busy   (busy),
        .sol    (sol),
        .qmat   (qmat)
    );

    crmv_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .px        (point_x),
        .py        (point_y),
        .pz        (point_z),
        .qmat      (qmat),
        .sol       (sol),
        .out_valid (done),
        .vx        (vec_x),
        .vy        (vec_y),
        .vz        (vec_z),
        .bad       (bad_result)
    );

endmodule
